FILE: sv/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/psjq_pkg.sv
// Types, codes and key helpers of the policy sorted job queue.
`timescale 1ns / 1ps
package psjq_pkg;

   localparam logic [1:0] CMD_INSERT    = 2'd0;
   localparam logic [1:0] CMD_POP       = 2'd1;
   localparam logic [1:0] CMD_WAIT_TIME = 2'd2;
   localparam logic [1:0] CMD_TIME_LEFT = 2'd3;

   localparam logic [1:0] POL_ARRIVAL  = 2'd0;
   localparam logic [1:0] POL_CPU      = 2'd1;
   localparam logic [1:0] POL_PRIORITY = 2'd2;
   localparam logic [1:0] POL_UNUSED   = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam int SUM_W = 37;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  priority_val;
      logic [31:0] cpu_need;
      logic [31:0] arrival;
   } job_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] job_id;
      logic [7:0]  job_priority;
      logic [31:0] job_cpu_time;
      logic [31:0] job_arrival;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [15:0]      out_id;
      logic [7:0]       out_priority;
      logic [31:0]      out_cpu_time;
      logic [31:0]      out_arrival;
      logic [SUM_W-1:0] time_sum;
      logic [5:0]       queue_count;
   } rsp_type;

   function automatic logic [1:0] eff_policy(input logic [1:0] p);
      eff_policy = (p == POL_UNUSED) ? POL_ARRIVAL : p;
   endfunction

   function automatic logic [31:0] job_key(input job_type j, input logic [1:0] pol);
      unique case (pol)
         POL_CPU:      job_key = j.cpu_need;
         POL_PRIORITY: job_key = {24'd0, j.priority_val};
         default:      job_key = j.arrival;
      endcase
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [31:0] v);
      logic [SUM_W:0] t;
      t = {1'b0, s} + (SUM_W+1)'(v);
      sat_add = t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
   endfunction

endpackage

FILE: sv/policy_sorted_job_queue.sv
// Top level of the policy sorted job queue: control sequencer and job memory.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   req_*  : one command per transfer (insert, pop, waiting-time query,
//            time-left query); req_stall is high while a command is in work.
//   rsp_*  : exactly one result per command, held in an output register
//            until a transfer with rsp_stall low takes it.
//   csr_*  : writes the ordering policy; always ready, write only when idle.
// Jobs sit in one DEPTH-entry memory used as a ring (head pointer), with a
// registered read. Every step of a walk is a read state, then a use state.
//   pop          : read the head entry, then take it and advance the head.
//   queries      : walk from the head summing CPU need (waiting time stops early).
//   insert       : scan for the place, then shift up and write the job.
//   insert after a policy change: an in-place insertion sort first,
//                  one insertion per stored job, then the insert itself.
// Reset empties the queue, sets policy and sort order to arrival time and
// drops any pending result. A stalled result does not block the next command
// from being taken; that command's result waits until the register is free.
module policy_sorted_job_queue #(
   parameter int DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  psjq_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output psjq_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = CW + 1;

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_RESORT_RD = 13'b0000000000010,
      S_RESORT_LD = 13'b0000000000100,
      S_SCAN_RD   = 13'b0000000001000,
      S_SCAN_CMP  = 13'b0000000010000,
      S_SHIFT_RD  = 13'b0000000100000,
      S_SHIFT_WR  = 13'b0000001000000,
      S_PLACE     = 13'b0000010000000,
      S_WALK_RD   = 13'b0000100000000,
      S_WALK_ACC  = 13'b0001000000000,
      S_POP_RD    = 13'b0010000000000,
      S_POP_LD    = 13'b0100000000000,
      S_DONE      = 13'b1000000000000
   } state_type;

   psjq_pkg::job_type mem [DEPTH];
   psjq_pkg::job_type rd_data_ff;

   state_type                   state_ff, state_in;
   logic [1:0]                  cmd_ff, cmd_in;
   psjq_pkg::job_type           job_ff, job_in;
   psjq_pkg::job_type           cur_ff, cur_in;
   psjq_pkg::job_type           pop_ff, pop_in;
   logic [CW-1:0]               n_ff, n_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic [CW-1:0]               pos_ff, pos_in;
   logic [CW-1:0]               rs_ff, rs_in;
   logic                        resort_ff, resort_in;
   logic [AW-1:0]               head_ff, head_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [1:0]                  sorted_ff, sorted_in;
   logic [1:0]                  policy_ff, policy_in;
   logic [psjq_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [1:0]                  status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   psjq_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        rd_en, wr_en;
   logic [CW-1:0]               rd_idx, wr_idx;
   logic [AW-1:0]               rd_addr, wr_addr;
   psjq_pkg::job_type           wr_data;
   logic [1:0]                  pol;
   logic [31:0]                 cur_key, rd_key;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
      logic [PW-1:0] t;
      t = PW'(h) + PW'(i);
      if (t >= PW'(DEPTH)) begin
         t = t - PW'(DEPTH);
      end
      phys = AW'(t);
   endfunction

   assign pol     = psjq_pkg::eff_policy(policy_ff);
   assign cur_key = psjq_pkg::job_key(cur_ff, pol);
   assign rd_key  = psjq_pkg::job_key(rd_data_ff, pol);
   assign rd_addr = phys(head_ff, rd_idx);
   assign wr_addr = phys(head_ff, wr_idx);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      job_in       = job_ff;
      cur_in       = cur_ff;
      pop_in       = pop_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      rs_in        = rs_ff;
      resort_in    = resort_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      sorted_in    = sorted_ff;
      policy_in    = policy_ff;
      sum_in       = sum_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_idx       = idx_ff;
      wr_en        = 1'b0;
      wr_idx       = idx_ff;
      wr_data      = rd_data_ff;

      if (csr_valid && csr_ready) begin
         policy_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.cmd;
               job_in    = '{req_data.job_id, req_data.job_priority,
                             req_data.job_cpu_time, req_data.job_arrival};
               pop_in    = '0;
               sum_in    = '0;
               status_in = psjq_pkg::ST_DONE;
               idx_in    = '0;
               unique case (req_data.cmd)
                  psjq_pkg::CMD_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = psjq_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else if (count_ff != '0 && sorted_ff != pol) begin
                        resort_in = 1'b1;
                        rs_in     = '0;
                        state_in  = S_RESORT_RD;
                     end else begin
                        cur_in   = job_in;
                        n_in     = count_ff;
                        state_in = S_SCAN_RD;
                     end
                  end
                  psjq_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        status_in = psjq_pkg::ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_POP_RD;
                     end
                  end
                  default: state_in = S_WALK_RD;
               endcase
            end
         end
         S_RESORT_RD: begin
            rd_en    = 1'b1;
            rd_idx   = rs_ff;
            state_in = S_RESORT_LD;
         end
         S_RESORT_LD: begin
            cur_in   = rd_data_ff;
            n_in     = rs_ff;
            idx_in   = '0;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (idx_ff == n_ff) begin
               pos_in   = idx_ff;
               idx_in   = n_ff;
               state_in = S_SHIFT_RD;
            end else begin
               rd_en    = 1'b1;
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (idx_ff == '0) begin
               if (rd_key > cur_key) begin
                  pos_in   = '0;
                  idx_in   = n_ff;
                  state_in = S_SHIFT_RD;
               end else begin
                  idx_in   = CW'(1);
                  state_in = S_SCAN_RD;
               end
            end else if (rd_key < cur_key) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SCAN_RD;
            end else begin
               pos_in   = idx_ff;
               idx_in   = n_ff;
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (idx_ff == pos_ff) begin
               state_in = S_PLACE;
            end else begin
               rd_en    = 1'b1;
               rd_idx   = idx_ff - CW'(1);
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - CW'(1);
            state_in = S_SHIFT_RD;
         end
         S_PLACE: begin
            wr_en   = 1'b1;
            wr_idx  = pos_ff;
            wr_data = cur_ff;
            if (resort_ff) begin
               rs_in = rs_ff + CW'(1);
               if (rs_ff + CW'(1) == count_ff) begin
                  resort_in = 1'b0;
                  cur_in    = job_ff;
                  n_in      = count_ff;
                  idx_in    = '0;
                  state_in  = S_SCAN_RD;
               end else begin
                  state_in = S_RESORT_RD;
               end
            end else begin
               count_in  = count_ff + CW'(1);
               sorted_in = pol;
               state_in  = S_DONE;
            end
         end
         S_WALK_RD: begin
            if (idx_ff == count_ff) begin
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_WALK_ACC;
            end
         end
         S_WALK_ACC: begin
            if (cmd_ff == psjq_pkg::CMD_WAIT_TIME &&
                psjq_pkg::job_key(job_ff, pol) < rd_key) begin
               state_in = S_DONE;
            end else begin
               sum_in   = psjq_pkg::sat_add(sum_ff, rd_data_ff.cpu_need);
               idx_in   = idx_ff + CW'(1);
               state_in = S_WALK_RD;
            end
         end
         S_POP_RD: begin
            rd_en    = 1'b1;
            rd_idx   = '0;
            state_in = S_POP_LD;
         end
         S_POP_LD: begin
            pop_in   = rd_data_ff;
            head_in  = phys(head_ff, CW'(1));
            count_in = count_ff - CW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.out_id       = pop_ff.id;
               rsp_in.out_priority = pop_ff.priority_val;
               rsp_in.out_cpu_time = pop_ff.cpu_need;
               rsp_in.out_arrival  = pop_ff.arrival;
               rsp_in.time_sum     = sum_ff;
               rsp_in.queue_count  = 6'(count_ff);
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         resort_ff    <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         sorted_ff    <= psjq_pkg::POL_ARRIVAL;
         policy_ff    <= psjq_pkg::POL_ARRIVAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resort_ff    <= resort_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         sorted_ff    <= sorted_in;
         policy_ff    <= policy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      job_ff    <= job_in;
      cur_ff    <= cur_in;
      pop_ff    <= pop_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      rs_ff     <= rs_in;
      sum_ff    <= sum_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   `ASSERT_CLK(a_state_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "count beyond depth")
   `ASSERT_CLK(a_count_stable, clock, reset,
      (state_ff != S_PLACE && state_ff != S_POP_LD) |=> $stable(count_ff),
      "count changed outside place or pop")
   `ASSERT_CLK(a_shift_range, clock, reset,
      (state_ff == S_SHIFT_RD) |-> (pos_ff <= idx_ff && idx_ff <= n_ff),
      "shift index out of range")
   `ASSERT_CLK(a_accept_leaves_idle, clock, reset,
      (req_valid && !req_stall) |=> (state_ff != S_IDLE), "accepted item not started")

endmodule
